/* src/q2e_pkg.sv */
// package for quaternion to euler conversion: widths, constants, atan table
package q2e_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int NST = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;

	// term width: products up to 2^30, sums and 1-2(..) fit in 36 bits
	localparam int TW = 36;
	// cordic datapath width (growth up to ~1.65x plus 90 degree swap)
	localparam int CW = 38;
	// angle accumulator width, units of 2^-16 degree
	localparam int AW = 26;
	// square root operand and result widths
	localparam int RW = 57;
	localparam int QW = 29;

	localparam logic signed [AW-1:0] DEG90 = AW'(90 <<< 16);
	localparam logic signed [TW-1:0] ONE_Q28 = TW'(64'sd1 <<< 28);
	localparam logic signed [15:0] ROLL_LIM = 16'sd23040;
	localparam logic signed [15:0] PITCH_LIM = 16'sd11520;

	typedef logic signed [CW-1:0] cval_t;
	typedef logic signed [AW-1:0] ang_t;

	// atan(2^-i) in units of 2^-16 degree
	function automatic ang_t atan_tab(input int i);
		ang_t r;
		unique case (i)
			0: r = AW'(2949120);
			1: r = AW'(1740967);
			2: r = AW'(919879);
			3: r = AW'(475137);
			4: r = AW'(234379);
			5: r = AW'(117304);
			6: r = AW'(58666);
			7: r = AW'(29335);
			8: r = AW'(14668);
			9: r = AW'(7334);
			10: r = AW'(3667);
			11: r = AW'(1833);
			12: r = AW'(917);
			13: r = AW'(458);
			14: r = AW'(229);
			15: r = AW'(115);
			16: r = AW'(57);
			17: r = AW'(29);
			18: r = AW'(14);
			19: r = AW'(7);
			20: r = AW'(4);
			21: r = AW'(2);
			22: r = AW'(1);
			default: r = '0;
		endcase
		return r;
	endfunction

	// round to 1/128 degree and clamp
	function automatic logic signed [15:0] to_out(input ang_t z, input logic signed [15:0] lim);
		logic signed [AW-1:0] r;
		logic signed [15:0] res;
		r = (z + ang_t'(256)) >>> 9;
		if (r > AW'(lim)) res = lim;
		else if (r < -AW'(lim)) res = -lim;
		else res = r[15:0];
		return res;
	endfunction

endpackage

/* src/q2e_cordic.sv */
// pipelined vectoring cordic atan2, one stage per register
module q2e_cordic (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  q2e_pkg::cval_t in_y,
	input  q2e_pkg::cval_t in_x,
	output logic out_valid,
	output q2e_pkg::ang_t out_z
);
	import q2e_pkg::*;

	logic  v_s [NST+1];
	cval_t x_s [NST+1];
	cval_t y_s [NST+1];
	ang_t  z_s [NST+1];
	logic  zr_s [NST+1];

	// quadrant pre-rotation stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		zr_s[0] <= (in_x == '0) && (in_y == '0);
		if (in_x < 0) begin
			if (in_y >= 0) begin
				x_s[0] <= in_y;
				y_s[0] <= -in_x;
				z_s[0] <= DEG90;
			end else begin
				x_s[0] <= -in_y;
				y_s[0] <= in_x;
				z_s[0] <= -DEG90;
			end
		end else begin
			x_s[0] <= in_x;
			y_s[0] <= in_y;
			z_s[0] <= '0;
		end
	end

	// micro-rotation stages
	for (genvar i = 0; i < NST; i++) begin : g_st
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			zr_s[i+1] <= zr_s[i];
			if (y_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + atan_tab(i);
			end else begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - atan_tab(i);
			end
		end
	end

	assign out_valid = v_s[NST];
	assign out_z = zr_s[NST] ? '0 : z_s[NST];

endmodule

/* src/quaternion_to_euler.sv */
// quaternion to euler angles top level
// Usage: drive quat_w/x/y/z (signed Q1.14) and pulse start; busy is always
// low so one transaction is accepted every cycle. Each transaction yields
// one result transaction: roll_deg, pitch_deg, yaw_deg (1/128 degree) and
// pitch_saturated, shown for exactly one cycle with done high.
// Pipeline: product, term and saturation stages, a restoring pitch square
// root (one result bit per stage), CORDIC_STAGES+1 cordic stages and one
// output register.
// Roll and yaw travel through delay lines to meet pitch.
// Throughput: one transaction per cycle, set by the fully pipelined
// square root and cordic stages.
// Reset: arst_n clears every valid bit; no results come out until
// transactions are accepted. Payload registers are not reset.
// The receiver cannot stall: done is a strobe and results are not held.
module quaternion_to_euler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic signed [15:0] quat_w,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	output logic        done,
	output logic signed [15:0] roll_deg,
	output logic signed [14:0] pitch_deg,
	output logic signed [15:0] yaw_deg,
	output logic        pitch_saturated
);
	import q2e_pkg::*;

	localparam int SQD = QW + 1;

	assign busy = 1'b0;

	// stage 1: products
	logic v_s1;
	logic signed [31:0] wx_s1, yz_s1, xx_s1, yy_s1, zz_s1, wy_s1, zx_s1, wz_s1, xy_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end
	always_ff @(posedge clk) begin
		wx_s1 <= quat_w * quat_x;
		yz_s1 <= quat_y * quat_z;
		xx_s1 <= quat_x * quat_x;
		yy_s1 <= quat_y * quat_y;
		zz_s1 <= quat_z * quat_z;
		wy_s1 <= quat_w * quat_y;
		zx_s1 <= quat_z * quat_x;
		wz_s1 <= quat_w * quat_z;
		xy_s1 <= quat_x * quat_y;
	end

	// stage 2: terms in Q28
	logic v_s2;
	logic signed [TW-1:0] sinr_s2, cosr_s2, sinp_s2, siny_s2, cosy_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		sinr_s2 <= (TW'(wx_s1) + TW'(yz_s1)) <<< 1;
		cosr_s2 <= ONE_Q28 - ((TW'(xx_s1) + TW'(yy_s1)) <<< 1);
		sinp_s2 <= (TW'(wy_s1) - TW'(zx_s1)) <<< 1;
		siny_s2 <= (TW'(wz_s1) + TW'(xy_s1)) <<< 1;
		cosy_s2 <= ONE_Q28 - ((TW'(yy_s1) + TW'(zz_s1)) <<< 1);
	end

	// stage 3: pitch saturation and 1 - s^2 (s fits 30 bits when unsaturated)
	logic v_s3, sat_s3, satneg_s3;
	logic signed [TW-1:0] sinr_s3, cosr_s3, sinp_s3, siny_s3, cosy_s3;
	logic signed [29:0] sp_c;
	logic [RW-1:0] rad_s3;
	assign sp_c = sinp_s2[29:0];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end
	always_ff @(posedge clk) begin
		sinr_s3 <= sinr_s2;
		cosr_s3 <= cosr_s2;
		sinp_s3 <= sinp_s2;
		siny_s3 <= siny_s2;
		cosy_s3 <= cosy_s2;
		sat_s3 <= (sinp_s2 >= ONE_Q28) || (sinp_s2 <= -ONE_Q28);
		satneg_s3 <= sinp_s2 < 0;
		rad_s3 <= RW'((64'd1 << 56) - 64'(sp_c * sp_c));
	end

	// pitch square root: one result bit per stage, restoring method
	logic [RW-1:0] rem_q [SQD];
	logic [QW-1:0] root_q [SQD];
	logic v_sq [SQD];
	logic sat_sq [SQD], neg_sq [SQD];
	logic signed [TW-1:0] sinr_sq [SQD], cosr_sq [SQD], sinp_sq [SQD];
	logic signed [TW-1:0] siny_sq [SQD], cosy_sq [SQD];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sq[0] <= 1'b0;
		end else begin
			v_sq[0] <= v_s3;
		end
	end
	always_ff @(posedge clk) begin
		rem_q[0] <= rad_s3;
		root_q[0] <= '0;
		sat_sq[0] <= sat_s3;
		neg_sq[0] <= satneg_s3;
		sinr_sq[0] <= sinr_s3;
		cosr_sq[0] <= cosr_s3;
		sinp_sq[0] <= sinp_s3;
		siny_sq[0] <= siny_s3;
		cosy_sq[0] <= cosy_s3;
	end

	for (genvar k = 0; k < SQD - 1; k++) begin : g_sq
		localparam int B = QW - 1 - k;
		logic [RW+1:0] trial;
		assign trial = ({2'b00, root_q[k]} << (B + 1)) + ((RW+2)'(1) << (2 * B));
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sq[k+1] <= 1'b0;
			end else begin
				v_sq[k+1] <= v_sq[k];
			end
		end
		always_ff @(posedge clk) begin
			if ({2'b00, rem_q[k]} >= trial) begin
				rem_q[k+1] <= rem_q[k] - trial[RW-1:0];
				root_q[k+1] <= root_q[k] | (QW'(1) << B);
			end else begin
				rem_q[k+1] <= rem_q[k];
				root_q[k+1] <= root_q[k];
			end
			sat_sq[k+1] <= sat_sq[k];
			neg_sq[k+1] <= neg_sq[k];
			sinr_sq[k+1] <= sinr_sq[k];
			cosr_sq[k+1] <= cosr_sq[k];
			sinp_sq[k+1] <= sinp_sq[k];
			siny_sq[k+1] <= siny_sq[k];
			cosy_sq[k+1] <= cosy_sq[k];
		end
	end

	// three cordic pipelines in parallel
	logic vr, vp, vy;
	ang_t zr, zp, zy;
	logic vin;
	assign vin = v_sq[SQD-1];

	q2e_cordic u_roll (
		.clk(clk), .arst_n(arst_n), .in_valid(vin),
		.in_y(CW'(sinr_sq[SQD-1])), .in_x(CW'(cosr_sq[SQD-1])),
		.out_valid(vr), .out_z(zr)
	);
	q2e_cordic u_pitch (
		.clk(clk), .arst_n(arst_n), .in_valid(vin),
		.in_y(CW'(sinp_sq[SQD-1])), .in_x(CW'($signed({1'b0, root_q[SQD-1]}))),
		.out_valid(vp), .out_z(zp)
	);
	q2e_cordic u_yaw (
		.clk(clk), .arst_n(arst_n), .in_valid(vin),
		.in_y(CW'(siny_sq[SQD-1])), .in_x(CW'(cosy_sq[SQD-1])),
		.out_valid(vy), .out_z(zy)
	);

	// saturation flags follow the cordic latency
	logic sat_d [NST+1];
	logic neg_d [NST+1];
	always_ff @(posedge clk) begin
		sat_d[0] <= sat_sq[SQD-1];
		neg_d[0] <= neg_sq[SQD-1];
	end
	for (genvar j = 0; j < NST; j++) begin : g_fl
		always_ff @(posedge clk) begin
			sat_d[j+1] <= sat_d[j];
			neg_d[j+1] <= neg_d[j];
		end
	end

	// output register
	logic signed [15:0] pitch_c;
	assign pitch_c = sat_d[NST] ? (neg_d[NST] ? -PITCH_LIM : PITCH_LIM)
		: to_out(zp, PITCH_LIM);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vp;
		end
	end
	always_ff @(posedge clk) begin
		roll_deg <= to_out(zr, ROLL_LIM);
		yaw_deg <= to_out(zy, ROLL_LIM);
		pitch_deg <= pitch_c[14:0];
		pitch_saturated <= sat_d[NST];
	end

	// checks
	a_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		(vr == vp) && (vy == vp)) else $error("cordic lanes out of step");
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> ##(SQD + NST + 2) done) else $error("result lost in pipeline");
	a_pitch: assert property (@(posedge clk) disable iff (!arst_n)
		(done && pitch_saturated) |-> (pitch_deg == 15'sd11520 || pitch_deg == -15'sd11520))
		else $error("saturated pitch not at limit");

endmodule

/* verif/tb.sv */
// testbench for quaternion to euler conversion: stimulus, prediction, result checking
`timescale 1ns / 100ps

module tb;

	localparam int LAT = 51;
	localparam longint CYCLE_LIMIT = 400000;
	localparam int ROLL_LIM = 23040;
	localparam int PITCH_LIM = 11520;
	localparam longint ONE_Q28 = 64'sd1 <<< 28;
	localparam longint DEG90 = 64'sd90 <<< 16;

	typedef struct {
		logic signed [15:0] roll;
		logic signed [14:0] pitch;
		logic signed [15:0] yaw;
		logic sat;
	} angles_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
	logic done;
	logic signed [15:0] roll_deg;
	logic signed [14:0] pitch_deg;
	logic signed [15:0] yaw_deg;
	logic pitch_saturated;

	angles_t expected_angles[$];
	int errors = 0;
	longint cycles = 0;

	quaternion_to_euler dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.done(done), .roll_deg(roll_deg), .pitch_deg(pitch_deg),
		.yaw_deg(yaw_deg), .pitch_saturated(pitch_saturated)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// atan(2^-i) in units of 2^-16 degree
	function automatic longint arctan_step(input int i);
		longint t[24] = '{2949120, 1740967, 919879, 475137, 234379, 117304, 58666,
			29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2,
			1, 0};
		return t[i];
	endfunction

	// vectoring cordic angle of (yv, xv), 2^-16 degree
	function automatic longint vector_angle(input longint yv, input longint xv);
		longint ang, tmp, xs, ys;
		ang = 0;
		if (xv == 0 && yv == 0) return 0;
		if (xv < 0) begin
			tmp = xv;
			if (yv >= 0) begin
				xv = yv; yv = -tmp; ang = DEG90;
			end else begin
				xv = -yv; yv = tmp; ang = -DEG90;
			end
		end
		for (int i = 0; i < 16; i++) begin
			xs = xv >>> i;
			ys = yv >>> i;
			if (yv >= 0) begin
				xv = xv + ys; yv = yv - xs; ang += arctan_step(i);
			end else begin
				xv = xv - ys; yv = yv + xs; ang -= arctan_step(i);
			end
		end
		return ang;
	endfunction

	function automatic longint round_clamp(input longint ang, input longint lim);
		longint r;
		r = (ang + 256) >>> 9;
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return r;
	endfunction

	function automatic longint floor_sqrt(input longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b; r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic angles_t euler_from_quat(input logic signed [15:0] qw,
		input logic signed [15:0] qx, input logic signed [15:0] qy,
		input logic signed [15:0] qz);
		longint w, x, y, z, sinr, cosr, sinp, siny, cosy, c;
		angles_t a;
		w = qw; x = qx; y = qy; z = qz;
		sinr = 2 * (w * x + y * z);
		cosr = ONE_Q28 - 2 * (x * x + y * y);
		sinp = 2 * (w * y - z * x);
		siny = 2 * (w * z + x * y);
		cosy = ONE_Q28 - 2 * (y * y + z * z);
		a.roll = 16'(round_clamp(vector_angle(sinr, cosr), ROLL_LIM));
		a.yaw = 16'(round_clamp(vector_angle(siny, cosy), ROLL_LIM));
		a.sat = 1'b0;
		if (sinp >= ONE_Q28) begin
			a.pitch = 15'(PITCH_LIM); a.sat = 1'b1;
		end else if (sinp <= -ONE_Q28) begin
			a.pitch = -15'(PITCH_LIM); a.sat = 1'b1;
		end else begin
			c = floor_sqrt((64'd1 << 56) - longint'(sinp * sinp));
			a.pitch = 15'(round_clamp(vector_angle(sinp, c), PITCH_LIM));
		end
		return a;
	endfunction

	// sender gap: mostly none or short, a few long
	task automatic idle_gap();
		int n;
		n = $urandom_range(0, 99);
		if (n < 50) n = 0;
		else if (n < 92) n = $urandom_range(1, 3);
		else n = $urandom_range(10, 60);
		repeat (n) begin
			@(posedge clk);
			start <= 1'b0;
		end
	endtask

	// send one transaction and record its expected angles
	task automatic send_quat(input logic signed [15:0] w, input logic signed [15:0] x,
		input logic signed [15:0] y, input logic signed [15:0] z, input bit gaps);
		if (gaps) idle_gap();
		@(posedge clk);
		start <= 1'b1;
		quat_w <= w; quat_x <= x; quat_y <= y; quat_z <= z;
		expected_angles.push_back(euler_from_quat(w, x, y, z));
		do @(negedge clk); while (busy);
	endtask

	function automatic logic signed [15:0] rand_comp();
		int m;
		m = $urandom_range(0, 9);
		if (m == 0) return 16'($urandom());
		return 16'($signed($urandom_range(0, 32768)) - 16384);
	endfunction

	// extremes, axis rotations, gimbal lock and zero cases
	task automatic test_directed();
		send_quat(16384, 0, 0, 0, 0);
		send_quat(0, 16384, 0, 0, 0);
		send_quat(0, 0, 16384, 0, 0);
		send_quat(0, 0, 0, 16384, 0);
		send_quat(-16384, 0, 0, 0, 0);
		send_quat(0, -16384, 0, 0, 0);
		send_quat(0, 0, -16384, 0, 0);
		send_quat(0, 0, 0, -16384, 0);
		send_quat(11585, 0, 11585, 0, 0);
		send_quat(11585, 0, -11585, 0, 0);
		send_quat(11586, 0, 11586, 0, 0);
		send_quat(8192, 8192, 8192, 8192, 0);
		send_quat(8192, -8192, 8192, -8192, 0);
		send_quat(0, 0, 0, 0, 0);
		send_quat(11585, 11585, 0, 0, 0);
		send_quat(11585, 0, 0, 11585, 0);
		send_quat(-32768, -32768, -32768, -32768, 0);
		send_quat(32767, 32767, 32767, 32767, 0);
		send_quat(32767, -32768, 32767, -32768, 0);
		send_quat(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 0);
		send_quat(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 0);
	endtask

	// random transactions, mostly near unit length, with back-to-back stretches
	task automatic test_random();
		real a, b, c, d, n;
		for (int i = 0; i < 1200; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp(),
					(i / 100) % 2 == 1);
			end else begin
				a = $signed($urandom_range(0, 2000)) - 1000;
				b = $signed($urandom_range(0, 2000)) - 1000;
				c = $signed($urandom_range(0, 2000)) - 1000;
				d = $signed($urandom_range(0, 2000)) - 1000;
				n = $sqrt(a * a + b * b + c * c + d * d);
				if (n == 0) n = 1;
				send_quat(16'($rtoi(16384.0 * a / n)), 16'($rtoi(16384.0 * b / n)),
					16'($rtoi(16384.0 * c / n)), 16'($rtoi(16384.0 * d / n)),
					(i / 100) % 2 == 1);
			end
		end
		@(posedge clk);
		start <= 1'b0;
	endtask

	// compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		angles_t e;
		cycles <= cycles + 1;
		if (arst_n && done) begin
			if (expected_angles.size() == 0) begin
				$error("unexpected result transaction");
				errors++;
			end else begin
				e = expected_angles.pop_front();
				if (roll_deg !== e.roll) begin
					$error("roll_deg expected %0d actual %0d", e.roll, roll_deg);
					errors++;
				end
				if (pitch_deg !== e.pitch) begin
					$error("pitch_deg expected %0d actual %0d", e.pitch, pitch_deg);
					errors++;
				end
				if (yaw_deg !== e.yaw) begin
					$error("yaw_deg expected %0d actual %0d", e.yaw, yaw_deg);
					errors++;
				end
				if (pitch_saturated !== e.sat) begin
					$error("pitch_saturated expected %0d actual %0d", e.sat,
						pitch_saturated);
					errors++;
				end
			end
		end
	end

	// run limit
	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("quaternion_to_euler: mismatch");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		quat_w = '0; quat_x = '0; quat_y = '0; quat_z = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random();
		while (expected_angles.size() != 0) @(posedge clk);
		repeat (LAT) @(posedge clk);
		if (errors == 0) begin
			$display("quaternion_to_euler: match");
		end else begin
			$display("quaternion_to_euler: mismatch");
		end
		$finish;
	end

endmodule
